[hdl/djrs_pkg.sv]
// Package for the distance jump rejecting smoother.
// Holds widths, outcome and register codes, the sequencer states and the
// request/response structs of the shared divide unit. No dependencies.
package djrs_pkg;

  localparam int DIST_W  = 20;
  localparam int KEYA_W  = 16;
  localparam int KEYN_W  = 8;
  localparam int CNT_W   = 3;
  localparam int OC_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  // Width of cand*n + x (n at most 7).
  localparam int SUM_W   = DIST_W + CNT_W;

  localparam logic [OC_W-1:0] OUT_PASS    = 3'd0;
  localparam logic [OC_W-1:0] OUT_RESTART = 3'd1;
  localparam logic [OC_W-1:0] OUT_SMOOTH  = 3'd2;
  localparam logic [OC_W-1:0] OUT_HELD    = 3'd3;
  localparam logic [OC_W-1:0] OUT_ACCEPT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAND_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONF_NEED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_SH = 2'd3;

  localparam logic [DIST_W-1:0] JUMP_THR_RST = 20'd2880;
  localparam logic [DIST_W-1:0] CAND_TOL_RST = 20'd1920;
  localparam logic [CNT_W-1:0]  CONF_NEED_RST = 3'd3;
  localparam logic [CNT_W-1:0]  SMOOTH_SH_RST = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_CHECK,
    ST_FINISH
  } djrs_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_DIV,
    DV_DONE
  } djrs_dv_phase_t;

  typedef struct packed {
    logic              start;
    logic [DIST_W-1:0] cand;
    logic [CNT_W-1:0]  n;
    logic [DIST_W-1:0] x;
  } djrs_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] quot;
  } djrs_div_rsp_t;

endpackage

[hdl/djrs_if.sv]
// Valid/ready channel interfaces for sample and result transactions.
// Depends on djrs_pkg for field widths.
interface djrs_in_if;
  logic                          valid;
  logic                          ready;
  logic [djrs_pkg::KEYA_W-1:0]   key_address;
  logic [djrs_pkg::KEYN_W-1:0]   key_number;
  logic [djrs_pkg::DIST_W-1:0]   sample_distance;
  logic                          sample_ok;

  modport source (output valid, key_address, key_number, sample_distance, sample_ok,
                  input ready);
  modport sink   (input valid, key_address, key_number, sample_distance, sample_ok,
                  output ready);
endinterface

interface djrs_out_if;
  logic                          valid;
  logic                          ready;
  logic [djrs_pkg::DIST_W-1:0]   stable_distance;
  logic [djrs_pkg::OC_W-1:0]     outcome;

  modport source (output valid, stable_distance, outcome, input ready);
  modport sink   (input valid, stable_distance, outcome, output ready);
endinterface

[hdl/djrs_div.sv]
// Shared add/subtract unit under a small sequencer: forms cand*n + x by
// shift-and-add, then divides by n+1 one quotient bit a cycle (restoring).
// Depends on djrs_pkg.
module djrs_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  djrs_pkg::djrs_div_req_t req,
  output djrs_pkg::djrs_div_rsp_t rsp
);
  import djrs_pkg::*;

  localparam int ADD_W = SUM_W + 1;

  djrs_dv_phase_t     phase_r, phase_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [DIST_W-1:0]  cand_r, cand_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;

  logic [ADD_W-1:0]   op_a, op_b;
  logic               op_sub;
  logic [ADD_W:0]     add_res;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     divisor;
  logic [CNT_W:0]     n_ext;
  logic [SUM_W-1:0]   mul_term;

  // the one adder; carry out on subtract means no borrow
  assign add_res = {1'b0, op_a} + {1'b0, (op_b ^ {ADD_W{op_sub}})} + {{ADD_W{1'b0}}, op_sub};

  assign trial    = {rem_r, acc_r[SUM_W-1]};
  assign divisor  = {1'b0, n_r} + {{CNT_W{1'b0}}, 1'b1};
  assign n_ext    = {1'b0, n_r};
  assign mul_term = n_ext[cnt_r[1:0]] ? ({{CNT_W{1'b0}}, cand_r} << cnt_r[1:0]) : '0;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    cand_nxt  = cand_r;
    n_nxt     = n_r;
    op_a      = {1'b0, acc_r};
    op_b      = {1'b0, mul_term};
    op_sub    = 1'b0;
    unique case (phase_r)
      DV_IDLE: begin
        if (req.start) begin
          cand_nxt  = req.cand;
          n_nxt     = req.n;
          acc_nxt   = {{CNT_W{1'b0}}, req.x};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = DV_MUL;
        end
      end
      DV_MUL: begin
        acc_nxt = add_res[SUM_W-1:0];
        if (cnt_r == 5'(CNT_W - 1)) begin
          cnt_nxt   = '0;
          phase_nxt = DV_DIV;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      DV_DIV: begin
        op_a   = {{(ADD_W-CNT_W-1){1'b0}}, trial};
        op_b   = {{(ADD_W-CNT_W-1){1'b0}}, divisor};
        op_sub = 1'b1;
        if (add_res[ADD_W]) begin
          rem_nxt = add_res[CNT_W-1:0];
        end else begin
          rem_nxt = trial[CNT_W-1:0];
        end
        acc_nxt = {acc_r[SUM_W-2:0], add_res[ADD_W]};
        if (cnt_r == 5'(SUM_W - 1)) begin
          phase_nxt = DV_DONE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      DV_DONE: begin
        phase_nxt = DV_IDLE;
      end
      default: phase_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= DV_IDLE;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    cand_r <= cand_nxt;
    n_r    <= n_nxt;
  end

  // quotient lies between its operands, so the low bits hold it all
  assign rsp.done = (phase_r == DV_DONE);
  assign rsp.quot = acc_r[DIST_W-1:0];

endmodule

[hdl/distance_jump_rejecting_smoother.sv]
// Top level of the distance jump rejecting smoother: tracking state, config
// registers, item sequencer and output register.
// Depends on djrs_pkg, djrs_if (channel interfaces) and djrs_div.
//
//  channel | dir | handshake         | payload
//  in_ch   | in  | valid/ready       | key_address, key_number, sample_distance, sample_ok
//  out_ch  | out | valid/ready       | stable_distance, outcome
//  cfg_*   | in  | cfg_we, no wait   | cfg_index, cfg_wdata
//
// One sample transaction at a time. Pass-through, restart and smoothed
// samples go from ST_EVAL straight to ST_FINISH; a new jump candidate passes
// ST_CHECK first; a confirming candidate waits in ST_DIV on the divide unit
// (3 shift-add steps for cand*n + x, 23 restoring quotient steps, then done).
// in_ch.ready is high only while the sequencer is idle; a finished result
// waits in the output register, which does not block the next accept, but a
// second result stalls in ST_FINISH until the first is taken.
// Reset (rst_n low, synchronous) clears tracking state and loads the
// register defaults; there is no clearing pass.
module distance_jump_rejecting_smoother (
  input  logic                             clk,
  input  logic                             rst_n,
  djrs_in_if.sink                          in_ch,
  djrs_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [djrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [djrs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import djrs_pkg::*;

  // configuration
  logic [DIST_W-1:0] thr_r, tol_r;
  logic [CNT_W-1:0]  need_r, shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= JUMP_THR_RST;
      tol_r   <= CAND_TOL_RST;
      need_r  <= CONF_NEED_RST;
      shift_r <= SMOOTH_SH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_JUMP_THR:  thr_r   <= cfg_wdata[DIST_W-1:0];
        CFG_CAND_TOL:  tol_r   <= cfg_wdata[DIST_W-1:0];
        CFG_CONF_NEED: need_r  <= cfg_wdata[CNT_W-1:0];
        CFG_SMOOTH_SH: shift_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  djrs_state_t        state_r, state_nxt;

  // latched sample
  logic [KEYA_W-1:0]  ka_r, ka_nxt;
  logic [KEYN_W-1:0]  kn_r, kn_nxt;
  logic [DIST_W-1:0]  x_r, x_nxt;
  logic               ok_r, ok_nxt;

  // tracking state
  logic               track_r, track_nxt;
  logic [KEYA_W-1:0]  tka_r, tka_nxt;
  logic [KEYN_W-1:0]  tkn_r, tkn_nxt;
  logic [DIST_W-1:0]  stable_r, stable_nxt;
  logic [DIST_W-1:0]  cand_r, cand_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // pending result and output register
  logic [DIST_W-1:0]  res_r, res_nxt;
  logic [OC_W-1:0]    oc_r, oc_nxt;
  logic [DIST_W-1:0]  out_dist_r, out_dist_nxt;
  logic [OC_W-1:0]    out_oc_r, out_oc_nxt;
  logic               out_valid_r, out_valid_nxt;

  djrs_div_req_t      div_req;
  djrs_div_rsp_t      div_rsp;

  djrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // deviations and the smoothing step (floor via arithmetic shift)
  logic signed [DIST_W:0] dev_s, cdev_s, step_s, smooth_s;
  logic [DIST_W-1:0]      dev_mag, cdev_mag, smooth_val;
  logic                   key_match;

  assign dev_s      = $signed({1'b0, x_r}) - $signed({1'b0, stable_r});
  assign cdev_s     = $signed({1'b0, x_r}) - $signed({1'b0, cand_r});
  assign dev_mag    = dev_s[DIST_W]  ? DIST_W'(-dev_s)  : dev_s[DIST_W-1:0];
  assign cdev_mag   = cdev_s[DIST_W] ? DIST_W'(-cdev_s) : cdev_s[DIST_W-1:0];
  assign step_s     = dev_s >>> shift_r;
  assign smooth_s   = $signed({1'b0, stable_r}) + step_s;
  // stays between old stable and sample, so 20 bits hold it
  assign smooth_val = smooth_s[DIST_W-1:0];
  assign key_match  = track_r && (tka_r == ka_r) && (tkn_r == kn_r);

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ka_nxt        = ka_r;
    kn_nxt        = kn_r;
    x_nxt         = x_r;
    ok_nxt        = ok_r;
    track_nxt     = track_r;
    tka_nxt       = tka_r;
    tkn_nxt       = tkn_r;
    stable_nxt    = stable_r;
    cand_nxt      = cand_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    oc_nxt        = oc_r;
    out_dist_nxt  = out_dist_r;
    out_oc_nxt    = out_oc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    div_req.start = 1'b0;
    div_req.cand  = cand_r;
    div_req.n     = cnt_r;
    div_req.x     = x_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          ka_nxt    = in_ch.key_address;
          kn_nxt    = in_ch.key_number;
          x_nxt     = in_ch.sample_distance;
          ok_nxt    = in_ch.sample_ok;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!ok_r) begin
          // invalid sample: pass through, state untouched
          res_nxt   = x_r;
          oc_nxt    = OUT_PASS;
          state_nxt = ST_FINISH;
        end else if (!key_match) begin
          track_nxt  = 1'b1;
          tka_nxt    = ka_r;
          tkn_nxt    = kn_r;
          cnt_nxt    = '0;
          stable_nxt = x_r;
          cand_nxt   = x_r;
          res_nxt    = x_r;
          oc_nxt     = OUT_RESTART;
          state_nxt  = ST_FINISH;
        end else if (dev_mag <= thr_r) begin
          stable_nxt = smooth_val;
          cnt_nxt    = '0;
          cand_nxt   = x_r;
          res_nxt    = smooth_val;
          oc_nxt     = OUT_SMOOTH;
          state_nxt  = ST_FINISH;
        end else if (cnt_r == '0 || cdev_mag > tol_r) begin
          // fresh jump candidate
          cand_nxt  = x_r;
          cnt_nxt   = CNT_W'(1);
          state_nxt = ST_CHECK;
        end else begin
          // confirming candidate: average through the divide unit
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          cand_nxt  = div_rsp.quot;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cnt_r >= need_r) begin
          stable_nxt = cand_r;
          cnt_nxt    = '0;
          res_nxt    = cand_r;
          oc_nxt     = OUT_ACCEPT;
        end else begin
          res_nxt = stable_r;
          oc_nxt  = OUT_HELD;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_dist_nxt  = res_r;
          out_oc_nxt    = oc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      track_r     <= 1'b0;
      tka_r       <= '0;
      tkn_r       <= '0;
      stable_r    <= '0;
      cand_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      track_r     <= track_nxt;
      tka_r       <= tka_nxt;
      tkn_r       <= tkn_nxt;
      stable_r    <= stable_nxt;
      cand_r      <= cand_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ka_r       <= ka_nxt;
    kn_r       <= kn_nxt;
    x_r        <= x_nxt;
    ok_r       <= ok_nxt;
    res_r      <= res_nxt;
    oc_r       <= oc_nxt;
    out_dist_r <= out_dist_nxt;
    out_oc_r   <= out_oc_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.stable_distance = out_dist_r;
  assign out_ch.outcome         = out_oc_r;

`ifndef SYNTHESIS
  // a stored count of seven only exists in the cycle it is checked
  a_cnt_below_seven: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CHECK) |-> (cnt_r != 3'd7))
    else $error("candidate count seven outside check state");

  // divide unit reports only while the sequencer waits on it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divide done outside divide state");

  // a new result appears only from the finish state
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("result loaded outside finish state");

  // no candidate is pending without a tracked key
  a_idle_track_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !track_r |-> (cnt_r == '0))
    else $error("candidate pending while not tracking");
`endif

endmodule

[sim/djrs_checker.sv]
`timescale 1ns / 100ps
// Result checker for the distance jump rejecting smoother: watches the sample,
// result and register ports, predicts each result and compares it.
// Depends on djrs_pkg for widths, outcome codes and register indexes.
module djrs_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [djrs_pkg::KEYA_W-1:0]     in_key_address,
  input  logic [djrs_pkg::KEYN_W-1:0]     in_key_number,
  input  logic [djrs_pkg::DIST_W-1:0]     in_sample_distance,
  input  logic                            in_sample_ok,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [djrs_pkg::DIST_W-1:0]     out_stable_distance,
  input  logic [djrs_pkg::OC_W-1:0]       out_outcome,
  input  logic                            cfg_we,
  input  logic [djrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [djrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  import djrs_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [OC_W-1:0]   outcome;
  } smoothed_t;

  smoothed_t pending_results[$];
  int mismatches = 0;

  // register mirror
  logic [DIST_W-1:0] thr_q, tol_q;
  logic [CNT_W-1:0]  need_q, shift_q;

  // tracking state mirror
  logic              trk_active;
  logic [KEYA_W-1:0] trk_ka;
  logic [KEYN_W-1:0] trk_kn;
  logic [DIST_W-1:0] stable_q, cand_q;
  logic [CNT_W-1:0]  cand_cnt;

  assign fail_count = mismatches;

  function automatic logic [DIST_W-1:0] dist_gap(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic smoothed_t track_sample(input logic [KEYA_W-1:0] ka,
                                             input logic [KEYN_W-1:0] kn,
                                             input logic [DIST_W-1:0] x,
                                             input logic ok);
    smoothed_t         r;
    logic [DIST_W:0]   mag;
    logic [DIST_W-1:0] step;
    logic [SUM_W-1:0]  cand_w, n_w, sum, quo;
    if (!ok) begin
      r.distance = x;
      r.outcome  = OUT_PASS;
    end else if (!trk_active || trk_ka != ka || trk_kn != kn) begin
      trk_active = 1'b1;
      trk_ka     = ka;
      trk_kn     = kn;
      cand_cnt   = '0;
      stable_q   = x;
      cand_q     = x;
      r.distance = x;
      r.outcome  = OUT_RESTART;
    end else if (dist_gap(x, stable_q) <= thr_q) begin
      // floor of the signed step: round the magnitude up when moving down
      if (x >= stable_q) begin
        stable_q = stable_q + ((x - stable_q) >> shift_q);
      end else begin
        mag      = {1'b0, stable_q - x} + ((21'd1 << shift_q) - 21'd1);
        mag      = mag >> shift_q;
        step     = mag[DIST_W-1:0];
        stable_q = stable_q - step;
      end
      cand_cnt   = '0;
      cand_q     = x;
      r.distance = stable_q;
      r.outcome  = OUT_SMOOTH;
    end else begin
      if (cand_cnt == '0 || dist_gap(x, cand_q) > tol_q) begin
        cand_q   = x;
        cand_cnt = 3'd1;
      end else begin
        cand_w   = '0;
        cand_w[DIST_W-1:0] = cand_q;
        n_w      = '0;
        n_w[CNT_W-1:0] = cand_cnt;
        sum      = cand_w * n_w + {{CNT_W{1'b0}}, x};
        quo      = sum / (n_w + 1'b1);
        cand_q   = quo[DIST_W-1:0];
        cand_cnt = cand_cnt + 3'd1;
      end
      if (cand_cnt >= need_q) begin
        stable_q  = cand_q;
        cand_cnt  = '0;
        r.outcome = OUT_ACCEPT;
      end else begin
        r.outcome = OUT_HELD;
      end
      r.distance = stable_q;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    smoothed_t got, want;
    if (!rst_n) begin
      thr_q      = JUMP_THR_RST;
      tol_q      = CAND_TOL_RST;
      need_q     = CONF_NEED_RST;
      shift_q    = SMOOTH_SH_RST;
      trk_active = 1'b0;
      trk_ka     = '0;
      trk_kn     = '0;
      stable_q   = '0;
      cand_q     = '0;
      cand_cnt   = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_JUMP_THR:  thr_q   = cfg_wdata[DIST_W-1:0];
          CFG_CAND_TOL:  tol_q   = cfg_wdata[DIST_W-1:0];
          CFG_CONF_NEED: need_q  = cfg_wdata[CNT_W-1:0];
          CFG_SMOOTH_SH: shift_q = cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.distance = out_stable_distance;
        got.outcome  = out_outcome;
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: distance %h outcome %0d",
                   $time, got.distance, got.outcome);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.distance !== want.distance) begin
            $display("%0t: stable_distance expected %h actual %h",
                     $time, want.distance, got.distance);
            mismatches++;
          end
          if (got.outcome !== want.outcome) begin
            $display("%0t: outcome expected %0d actual %0d",
                     $time, want.outcome, got.outcome);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(track_sample(in_key_address, in_key_number,
                                               in_sample_distance, in_sample_ok));
    end
    pending <= pending_results.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Top of the distance jump rejecting smoother testbench: clock, reset,
// sample and register stimulus, receiver stalls, watchdog and verdict.
// Depends on djrs_pkg, djrs_if, the smoother RTL and djrs_checker.
module tb;
  import djrs_pkg::*;

  localparam int DIST_MAX       = (1 << DIST_W) - 1;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction at all
  localparam int SETTLE_CYCLES  = 40;    // the longest item is a confirming average
  localparam int PHASE_ITEMS    = 185;
  localparam int NUM_PHASES     = 6;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // idling knobs, in percent per cycle
  int sender_idle;
  int recv_stall;

  // stimulus-side copy of the thresholds, used only to shape samples
  int thr_i;
  int tol_i;

  // current key and a rough idea of where the stable value sits
  logic [KEYA_W-1:0] cur_ka;
  logic [KEYN_W-1:0] cur_kn;
  int                base_dist;

  djrs_in_if  in_ch ();
  djrs_out_if out_ch ();

  distance_jump_rejecting_smoother dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  djrs_checker smoother_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_key_address      (in_ch.key_address),
    .in_key_number       (in_ch.key_number),
    .in_sample_distance  (in_ch.sample_distance),
    .in_sample_ok        (in_ch.sample_ok),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_stable_distance (out_ch.stable_distance),
    .out_outcome         (out_ch.outcome),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: ready toggles at random by the current stall rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Watchdog: a run that stops moving transactions is a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, %0d results outstanding", $time, pending);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int dist_clamp(input int v);
    if (v < 0) return 0;
    if (v > DIST_MAX) return DIST_MAX;
    return v;
  endfunction

  // One sample transaction. An optional sender gap comes first; valid is only
  // lowered when a gap follows, so back-to-back transactions keep it high.
  task automatic send_sample(input logic [KEYA_W-1:0] ka, input logic [KEYN_W-1:0] kn,
                             input int d, input logic ok);
    int gap;
    int dc;
    gap = 0;
    dc  = dist_clamp(d);
    while (gap < 40 && $urandom_range(0, 99) < sender_idle) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.key_address     <= ka;
    in_ch.key_number      <= kn;
    in_ch.sample_distance <= dc[DIST_W-1:0];
    in_ch.sample_ok       <= ok;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic drain;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers, one per cycle; only called while idle.
  task automatic program_regs(input int thr, input int tol, input int conf, input int sh);
    logic [CFG_DATA_W-1:0] w;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_JUMP_THR;
    cfg_wdata <= thr[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_CAND_TOL;
    cfg_wdata <= tol[CFG_DATA_W-1:0];
    @(posedge clk);
    w = '0;
    w[CNT_W-1:0] = conf[CNT_W-1:0];
    cfg_index <= CFG_CONF_NEED;
    cfg_wdata <= w;
    @(posedge clk);
    w = '0;
    w[CNT_W-1:0] = sh[CNT_W-1:0];
    cfg_index <= CFG_SMOOTH_SH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_i  = thr;
    tol_i  = tol;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin sender_idle = 0;  recv_stall = 0;  end
      1: begin sender_idle = 61; recv_stall = 0;  end
      2: begin sender_idle = 0;  recv_stall = 61; end
      default: begin sender_idle = 8; recv_stall = 8; end
    endcase
  endtask

  // Random traffic, mostly well-formed: smoothing runs on one key and bursts
  // of jump samples clustered around a target, so candidates build up and get
  // accepted. The rest is key changes, invalid samples and full-range noise.
  task automatic run_random(input int n_items);
    int          done_items, pick, span, off, jump, target, burst, k, tol_half;
    logic [31:0] rnd;
    done_items = 0;
    while (done_items < n_items) begin
      pick = int'($urandom_range(0, 99));
      rnd  = $urandom;
      if (pick < 4) begin
        // new key: restart
        cur_ka    = rnd[15:0];
        cur_kn    = rnd[23:16];
        base_dist = int'($urandom_range(0, DIST_MAX));
        send_sample(cur_ka, cur_kn, base_dist, 1'b1);
        done_items++;
      end else if (pick < 10) begin
        // invalid sample, any key; state must stay put
        send_sample(rnd[24] ? cur_ka : rnd[15:0], rnd[25] ? cur_kn : rnd[23:16],
                    int'($urandom_range(0, DIST_MAX)), 1'b0);
        done_items++;
      end else if (pick < 14) begin
        send_sample(cur_ka, cur_kn, int'($urandom_range(0, DIST_MAX)), 1'b1);
        done_items++;
      end else if (pick < 50) begin
        // small deviation, sometimes right at the threshold
        span = (thr_i > 200000) ? 200000 : thr_i;
        off  = int'($urandom_range(0, 2 * span)) - span;
        if (rnd[7:0] == 8'd0) off = rnd[8] ? thr_i : -thr_i;
        base_dist = dist_clamp(base_dist + off);
        send_sample(cur_ka, cur_kn, base_dist, 1'b1);
        done_items++;
      end else begin
        // jump burst around a target, a few strays beyond tolerance
        jump   = thr_i + 1 + int'($urandom_range(0, 4000));
        target = rnd[0] ? base_dist + jump : base_dist - jump;
        if (target > DIST_MAX || target < 0)
          target = rnd[0] ? base_dist - jump : base_dist + jump;
        target   = dist_clamp(target);
        burst    = int'($urandom_range(1, 8));
        tol_half = (tol_i > 400000) ? 200000 : tol_i / 2;
        for (k = 0; k < burst && done_items < n_items; k++) begin
          if ($urandom_range(0, 5) == 0) off = tol_i + 1 + int'($urandom_range(0, 3000));
          else off = int'($urandom_range(0, tol_half));
          if ($urandom_range(0, 1) == 1) off = -off;
          send_sample(cur_ka, cur_kn, target + off, 1'b1);
          done_items++;
        end
        base_dist = target;
      end
    end
  endtask

  initial begin
    int p;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.key_address     = '0;
    in_ch.key_number      = '0;
    in_ch.sample_distance = '0;
    in_ch.sample_ok       = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_JUMP_THR;
    cfg_wdata             = '0;
    sender_idle           = 0;
    recv_stall            = 0;
    thr_i                 = int'(JUMP_THR_RST);
    tol_i                 = int'(CAND_TOL_RST);
    cur_ka                = '0;
    cur_kn                = '0;
    base_dist             = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset defaults (thr 2880, tol 1920, 3 confirmations,
    // shift 2).
    send_sample(16'h0000, 8'h00, DIST_MAX, 1'b0);            // invalid before tracking
    send_sample(16'hFFFF, 8'hFF, 524288, 1'b1);              // first sample: restart
    send_sample(16'hFFFF, 8'hFF, 524288 + 2880, 1'b1);       // deviation == threshold
    send_sample(16'hFFFF, 8'hFF, 525008 - 7, 1'b1);          // downward step, floor
    send_sample(16'hFFFF, 8'hFF, 525006 + 2881, 1'b1);       // threshold + 1: held
    send_sample(16'hFFFF, 8'hFF, 527887 + 1920, 1'b1);       // spread == tolerance
    send_sample(16'hFFFF, 8'hFF, 527887 + 100, 1'b1);        // third one: accepted
    send_sample(16'hFFFF, 8'hFF, 0, 1'b0);                   // invalid mid-track
    send_sample(16'hFFFF, 8'hFF, 0, 1'b1);                   // far jump: held
    send_sample(16'hFFFF, 8'hFF, DIST_MAX, 1'b1);            // outside tolerance: new cand
    send_sample(16'hFFFF, 8'h00, 1000, 1'b1);                // key number change
    send_sample(16'h0000, 8'h00, 0, 1'b1);                   // key address change
    send_sample(16'h0000, 8'h00, DIST_MAX, 1'b1);            // full-scale jump
    drain();
    // one confirmation, shift of zero
    program_regs(2880, 1920, 1, 0);
    send_sample(16'h0000, 8'h00, 5, 1'b1);                   // stable takes sample
    send_sample(16'h0000, 8'h00, 100000, 1'b1);              // accepted at once
    drain();
    // lower the confirmation count while a candidate is pending
    program_regs(2880, 1920, 7, 2);
    send_sample(16'h0000, 8'h00, 200000, 1'b1);
    send_sample(16'h0000, 8'h00, 200010, 1'b1);
    drain();
    program_regs(2880, 1920, 2, 2);
    send_sample(16'h0000, 8'h00, 200020, 1'b1);              // pending one accepted
    drain();
    // zero confirmations: every jump goes straight through
    program_regs(2880, 1920, 0, 2);
    send_sample(16'h0000, 8'h00, 900000, 1'b1);
    send_sample(16'h0000, 8'h00, 900001, 1'b1);
    drain();

    cur_ka    = 16'h0000;
    cur_kn    = 8'h00;
    base_dist = 900001;

    // Random phases: defaults, both extremes, then random settings. Idling
    // rotates through none / sender / receiver / both.
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_regs(int'(JUMP_THR_RST), int'(CAND_TOL_RST),
                        int'(CONF_NEED_RST), int'(SMOOTH_SH_RST));
        1: program_regs(0, 0, 1, 0);
        2: program_regs(DIST_MAX, DIST_MAX, 7, 7);
        default: program_regs(int'($urandom_range(0, 6000)), int'($urandom_range(0, 4000)),
                              int'($urandom_range(1, 7)), int'($urandom_range(0, 7)));
      endcase
      set_idling(p % 4);
      run_random(PHASE_ITEMS);
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
